// ----- rtl/core/least_loaded_backend_selector_defines.svh -----
// ---------------------------------------------------------------------------
// Least-loaded backend selector: assertion macros
// Checks are written through these macros and are compiled out when
// NO_ASSERTIONS is defined. They expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef LEAST_LOADED_BACKEND_SELECTOR_DEFINES_SVH
`define LEAST_LOADED_BACKEND_SELECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define LLBS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llbs check failed");

// Consequent must hold in the cycle after the antecedent.
`define LLBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llbs check failed");

`else

`define LLBS_ASSERT_SAME(lbl, ante, cons)
`define LLBS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/llbs_pkg.sv -----
// ---------------------------------------------------------------------------
// llbs_pkg
// Shared types and constants for the least-loaded backend selector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package llbs_pkg;

  localparam int MAX_SERVERS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int PORT_W   = 16;
  localparam int SLOT_W   = 4;
  localparam int TOTAL_W  = 32;
  localparam int ACTIVE_W = 5;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_PICK   = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_MARK   = 2'd3
  } action_t;

  typedef struct packed {
    action_t              action;
    logic [SLOT_W-1:0]    slot;
    logic [PORT_W-1:0]    port;
    logic [TOTAL_W-1:0]   request_total;
    logic [TOTAL_W-1:0]   error_total;
  } in_item_t;

  typedef struct packed {
    logic [PORT_W-1:0] chosen_port;
    logic              none_live;
    logic              port_matched;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch transaction, reset scan
    logic scan;    // step the table scan
    logic commit;  // write back entry, load result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- rtl/core/least_loaded_backend_selector.sv -----
// Usage: one transaction in on in_valid/in_ready (in_data: action, slot, port,
// request_total, error_total), exactly one result out on out_valid/out_ready
// (out_data: chosen_port, none_live, port_matched). active_count is written
// through cfg_wr_en/cfg_wr_data; the user must do so only whilst the block is
// idle; the block itself does not enforce it. One transaction is handled at a time.
// With L = min(active_count, MAX_SERVERS) a pick, report or mark-down scans
// at most L table entries (one entry read per cycle from the single-read-port
// memory, one compare per cycle), ending early on a zero-count live entry or
// a port match; a load reads none. A commit cycle then writes the entry back
// and loads the result register. in_ready returns once the controller is
// back in idle, so a new transaction is not taken before the last one has
// committed.
// Reset (rst_n, synchronous, active low) clears active_count, the result
// valid bit and the per-entry valid bits, so every slot reads as port 0, up,
// zero counts. A stalled out_ready holds the result; a finished transaction
// waits in its commit cycle until the result register is free.
// ---------------------------------------------------------------------------
// least_loaded_backend_selector
// Least-connections backend selector: controller plus datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "least_loaded_backend_selector_defines.svh"

module least_loaded_backend_selector #(
  parameter int MAX_SERVERS = llbs_pkg::MAX_SERVERS_DEF,
  parameter int COUNT_WIDTH = llbs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [llbs_pkg::ACTIVE_W-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  llbs_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output llbs_pkg::out_item_t           out_data
);

  llbs_pkg::dp_cmd_t cmd;
  llbs_pkg::dp_sts_t sts;

  llbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  llbs_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cmd         (cmd),
    .sts         (sts)
  );

  // a commit never overwrites a result still waiting downstream
  `LLBS_ASSERT_SAME(a_commit_free, cmd.commit, sts.out_free)
  // every commit presents a result on the next cycle
  `LLBS_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid)
  // one transaction in flight: no new accept right after one
  `LLBS_ASSERT_NEXT(a_single_txn, in_valid && in_ready, !in_ready)
  // controller issues at most one command per cycle
  `LLBS_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0({cmd.start, cmd.scan, cmd.commit}))

endmodule

// ----- rtl/core/llbs_ctrl.sv -----
// ---------------------------------------------------------------------------
// llbs_ctrl
// Sequencer: accept, scan the table, commit the write-back and result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module llbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  llbs_pkg::dp_sts_t sts,
  output llbs_pkg::dp_cmd_t cmd
);

  llbs_pkg::state_t state_r;
  llbs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      llbs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = llbs_pkg::ST_SCAN;
        end
      end
      llbs_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = llbs_pkg::ST_COMMIT;
        end
      end
      llbs_pkg::ST_COMMIT: begin
        // hold until the result register can take the new result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = llbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = llbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/llbs_dp.sv -----
// ---------------------------------------------------------------------------
// llbs_dp
// Server table memory, scan/compare unit, write-back and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module llbs_dp #(
  parameter int MAX_SERVERS = llbs_pkg::MAX_SERVERS_DEF,
  parameter int COUNT_WIDTH = llbs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [llbs_pkg::ACTIVE_W-1:0]   cfg_wr_data,
  input  llbs_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output llbs_pkg::out_item_t             out_data,
  input  llbs_pkg::dp_cmd_t               cmd,
  output llbs_pkg::dp_sts_t               sts
);

  localparam int IDX_W     = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W     = $clog2(MAX_SERVERS + 1);
  localparam int CMP_W     = (CNT_W > llbs_pkg::ACTIVE_W) ? CNT_W : llbs_pkg::ACTIVE_W;
  localparam int E_ERR_LO  = 0;
  localparam int E_REQ_LO  = COUNT_WIDTH;
  localparam int E_DOWN    = 2 * COUNT_WIDTH;
  localparam int E_PORT_LO = 2 * COUNT_WIDTH + 1;
  localparam int ENT_W     = E_PORT_LO + llbs_pkg::PORT_W;

  // configuration
  logic [llbs_pkg::ACTIVE_W-1:0] cfg_active_r;

  // latched transaction
  llbs_pkg::in_item_t item_r;

  // table: memory plus per-entry valid bits (invalid reads as zero)
  logic [ENT_W-1:0]       mem [MAX_SERVERS];
  logic [MAX_SERVERS-1:0] vld_r;

  // scan pipeline
  logic [CNT_W-1:0]  scan_idx_r;
  logic              ev_vld_r;
  logic [IDX_W-1:0]  ev_idx_r;
  logic [ENT_W-1:0]  rd_ent_r;
  logic              rd_vbit_r;

  // best / matched entry
  logic                        found_r;
  logic [IDX_W-1:0]            best_idx_r;
  logic [llbs_pkg::PORT_W-1:0] best_port_r;
  logic [COUNT_WIDTH-1:0]      best_req_r;
  logic [COUNT_WIDTH-1:0]      best_err_r;

  // result register
  logic                out_valid_r;
  llbs_pkg::out_item_t out_data_r;

  logic [CMP_W-1:0]            act_ext;
  logic [CMP_W-1:0]            max_ext;
  logic [CNT_W-1:0]            lim;
  logic                        more;
  logic                        issue;
  logic [ENT_W-1:0]            ent;
  logic [llbs_pkg::PORT_W-1:0] ent_port;
  logic                        ent_down;
  logic [COUNT_WIDTH-1:0]      ent_req;
  logic [COUNT_WIDTH-1:0]      ent_err;
  logic                        is_pick;
  logic                        hit_now;
  logic                        upd_now;
  logic                        better;
  logic [COUNT_WIDTH-1:0]      req_clamp;
  logic [COUNT_WIDTH-1:0]      err_clamp;
  logic [COUNT_WIDTH-1:0]      req_inc;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [ENT_W-1:0]            wr_data;
  llbs_pkg::out_item_t         res;

  // scan limit: min(active_count, MAX_SERVERS); loads do not scan
  assign act_ext = CMP_W'(cfg_active_r);
  assign max_ext = CMP_W'(MAX_SERVERS);
  always_comb begin
    if (item_r.action == llbs_pkg::ACT_LOAD) begin
      lim = '0;
    end else if (act_ext > max_ext) begin
      lim = CNT_W'(max_ext);
    end else begin
      lim = CNT_W'(act_ext);
    end
  end

  assign more  = (scan_idx_r < lim);
  assign issue = cmd.scan && more;

  assign ent      = rd_vbit_r ? rd_ent_r : '0;
  assign ent_port = ent[E_PORT_LO +: llbs_pkg::PORT_W];
  assign ent_down = ent[E_DOWN];
  assign ent_req  = ent[E_REQ_LO +: COUNT_WIDTH];
  assign ent_err  = ent[E_ERR_LO +: COUNT_WIDTH];

  assign is_pick = (item_r.action == llbs_pkg::ACT_PICK);
  assign better  = !found_r || (ent_req < best_req_r) ||
                   ((ent_req == best_req_r) && (ent_err < best_err_r));

  always_comb begin
    hit_now = 1'b0;
    upd_now = 1'b0;
    if (ev_vld_r) begin
      if (is_pick) begin
        hit_now = !ent_down && (ent_req == '0);
        upd_now = !ent_down && (hit_now || better);
      end else begin
        hit_now = (ent_port == item_r.port);
        upd_now = hit_now;
      end
    end
  end

  assign sts.scan_done = hit_now || !more;
  assign sts.out_free  = !out_valid_r || out_ready;

  // reported totals saturate at the count width
  assign req_clamp = ((item_r.request_total >> COUNT_WIDTH) != '0) ? '1
                     : COUNT_WIDTH'(item_r.request_total);
  assign err_clamp = ((item_r.error_total >> COUNT_WIDTH) != '0) ? '1
                     : COUNT_WIDTH'(item_r.error_total);
  assign req_inc   = (best_req_r == '1) ? best_req_r : best_req_r + COUNT_WIDTH'(1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_idx_r;
    wr_data = {best_port_r, 1'b0, best_req_r, best_err_r};
    res     = '0;
    case (item_r.action)
      llbs_pkg::ACT_LOAD: begin
        wr_en   = cmd.commit && (32'(item_r.slot) < MAX_SERVERS);
        wr_addr = IDX_W'(item_r.slot);
        wr_data = {item_r.port, 1'b0, {COUNT_WIDTH{1'b0}}, {COUNT_WIDTH{1'b0}}};
      end
      llbs_pkg::ACT_PICK: begin
        wr_en           = cmd.commit && found_r;
        wr_data         = {best_port_r, 1'b0, req_inc, best_err_r};
        res.chosen_port = found_r ? best_port_r : '0;
        res.none_live   = !found_r;
      end
      llbs_pkg::ACT_REPORT: begin
        wr_en            = cmd.commit && found_r;
        wr_data          = {best_port_r, 1'b0, req_clamp, err_clamp};
        res.port_matched = found_r;
      end
      llbs_pkg::ACT_MARK: begin
        wr_en            = cmd.commit && found_r;
        wr_data          = {best_port_r, 1'b1, best_req_r, best_err_r};
        res.port_matched = found_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= '0;
      vld_r        <= '0;
      scan_idx_r   <= '0;
      ev_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_active_r <= cfg_wr_data;
      end
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.start) begin
        scan_idx_r <= '0;
        ev_vld_r   <= 1'b0;
        found_r    <= 1'b0;
      end else if (cmd.scan) begin
        ev_vld_r <= more;
        if (more) begin
          scan_idx_r <= scan_idx_r + CNT_W'(1);
        end
        if (upd_now) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_ent_r  <= mem[scan_idx_r[IDX_W-1:0]];
      rd_vbit_r <= vld_r[scan_idx_r[IDX_W-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_r <= in_data;
    end
    if (cmd.scan) begin
      ev_idx_r <= scan_idx_r[IDX_W-1:0];
      if (upd_now) begin
        best_idx_r  <= ev_idx_r;
        best_port_r <= ent_port;
        best_req_r  <= ent_req;
        best_err_r  <= ent_err;
      end
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/tb_least_loaded_backend_selector.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_least_loaded_backend_selector
// Self-checking bench for the least-loaded backend selector. A scoreboard
// class keeps its own copy of the server table and the slot count. It works
// out the result of every accepted transaction and checks the results in
// order. Directed corner cases run first, then random traffic over several
// slot counts, with idle cycles on the input and output sides.
// ---------------------------------------------------------------------------

module tb_least_loaded_backend_selector;
  import llbs_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int SERVERS      = MAX_SERVERS_DEF;
  localparam int LIMIT_CYCLES = 400000;
  // pause taken once all outstanding results have drained
  localparam int IDLE_GAP     = 4;
  localparam int SEG_ITEMS    = 150;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;

  typedef logic [COUNT_WIDTH_DEF-1:0] count_t;

  // -------------------------------------------------------------------------
  // Scoreboard: mirror of the server table plus the queue of outstanding
  // results. note_request() updates the mirror for an accepted transaction
  // and queues its result; check_outcome() compares an accepted result with
  // the oldest one queued.
  // -------------------------------------------------------------------------
  class selector_scoreboard;
    logic [PORT_W-1:0]   port_tbl [SERVERS];
    bit                  down_flag [SERVERS];
    count_t              req_cnt [SERVERS];
    count_t              err_cnt [SERVERS];
    logic [ACTIVE_W-1:0] active_count;
    out_item_t           expected_q [$];
    int                  errors;

    function new();
      for (int i = 0; i < SERVERS; i++) begin
        port_tbl[i]  = '0;
        down_flag[i] = 1'b0;
        req_cnt[i]   = '0;
        err_cnt[i]   = '0;
      end
      active_count = '0;
      errors       = 0;
    endfunction

    function void set_active(logic [ACTIVE_W-1:0] v);
      active_count = v;
    endfunction

    // slots actually scanned: the count is capped at the table size
    function int scan_len();
      return (active_count > SERVERS) ? SERVERS : int'(active_count);
    endfunction

    function count_t saturate(logic [TOTAL_W-1:0] v);
      longint unsigned wide;
      wide = v;
      if (wide > CNT_MAX) return count_t'(CNT_MAX);
      return count_t'(wide);
    endfunction

    function void note_request(in_item_t it);
      out_item_t res;
      int        n;
      int        best;
      int        hit;
      bit        found;
      res   = '0;
      n     = scan_len();
      best  = 0;
      hit   = -1;
      found = 1'b0;
      case (it.action)
        ACT_LOAD: begin
          // loads go anywhere in the table, whatever the slot count
          port_tbl[it.slot]  = it.port;
          down_flag[it.slot] = 1'b0;
          req_cnt[it.slot]   = '0;
          err_cnt[it.slot]   = '0;
        end
        ACT_PICK: begin
          for (int i = 0; i < n; i++) begin
            if (down_flag[i]) continue;
            // an idle server wins outright
            if (req_cnt[i] == 0) begin
              best  = i;
              found = 1'b1;
              break;
            end
            // strict compares: a full tie keeps the earlier slot
            if (!found || req_cnt[i] < req_cnt[best] ||
                (req_cnt[i] == req_cnt[best] && err_cnt[i] < err_cnt[best])) begin
              best  = i;
              found = 1'b1;
            end
          end
          if (found) begin
            if (req_cnt[best] != CNT_MAX) req_cnt[best] = req_cnt[best] + 1'b1;
            res.chosen_port = port_tbl[best];
          end else begin
            res.none_live = 1'b1;
          end
        end
        default: begin
          // report and mark-down act on the lowest matching slot only
          for (int i = 0; i < n && hit < 0; i++)
            if (port_tbl[i] == it.port) hit = i;
          if (hit >= 0) begin
            res.port_matched = 1'b1;
            if (it.action == ACT_REPORT) begin
              req_cnt[hit]   = saturate(it.request_total);
              err_cnt[hit]   = saturate(it.error_total);
              down_flag[hit] = 1'b0;
            end else begin
              down_flag[hit] = 1'b1;
            end
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_outcome(out_item_t got);
      out_item_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result transaction with none outstanding: %p", got);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.chosen_port !== exp_res.chosen_port) begin
        $error("chosen_port: expected %h, got %h", exp_res.chosen_port, got.chosen_port);
        errors++;
      end
      if (got.none_live !== exp_res.none_live) begin
        $error("none_live: expected %b, got %b", exp_res.none_live, got.none_live);
        errors++;
      end
      if (got.port_matched !== exp_res.port_matched) begin
        $error("port_matched: expected %b, got %b", exp_res.port_matched, got.port_matched);
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT signals; the ones the bench drives are all known from time zero
  // -------------------------------------------------------------------------
  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [ACTIVE_W-1:0] cfg_wr_data = '0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  in_item_t            in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  out_item_t           out_data;

  selector_scoreboard sb;
  int                 send_idle_pct = 14;
  int                 recv_idle_pct = 47;
  int                 cycle_count   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  least_loaded_backend_selector dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  // Result side: check on the handshake (pre-edge values), then pick the
  // ready level for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_outcome(out_data);
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------

  // Offer one transaction; valid drops only when an idle gap is taken, so a
  // back-to-back transaction keeps valid high across the edge.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // Slot count changes only with the block idle
  task automatic program_active_count(input logic [ACTIVE_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_active(v);
  endtask

  function automatic in_item_t make_request(action_t a, logic [SLOT_W-1:0] s,
                                            logic [PORT_W-1:0] p,
                                            logic [TOTAL_W-1:0] rq,
                                            logic [TOTAL_W-1:0] er);
    in_item_t it;
    it.action        = a;
    it.slot          = s;
    it.port          = p;
    it.request_total = rq;
    it.error_total   = er;
    return it;
  endfunction

  // Small totals give plenty of ties and idle servers; the rest exercises
  // the full range and saturation.
  function automatic logic [TOTAL_W-1:0] random_total();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return TOTAL_W'($urandom_range(3));
      5:             return '1;
      6:             return '1 - TOTAL_W'($urandom_range(2));
      default:       return $urandom;
    endcase
  endfunction

  // Picks most often, with reports and mark-downs aimed at ports in the scanned
  // range so they usually hit; the odd random port checks the miss path.
  function automatic in_item_t random_request();
    in_item_t it;
    int       n;
    int       roll;
    n                = sb.scan_len();
    it.slot          = SLOT_W'($urandom);
    it.port          = PORT_W'($urandom);
    it.request_total = $urandom;
    it.error_total   = $urandom;
    roll             = $urandom_range(99);
    if (roll < 20) begin
      it.action = ACT_LOAD;
      if (n > 0 && $urandom_range(3) != 0) it.slot = SLOT_W'($urandom_range(n - 1));
      case ($urandom_range(9))
        0:       it.port = '0;
        1:       it.port = '1;
        2, 3, 4: it.port = PORT_W'($urandom_range(7));   // duplicates likely
        default: ;
      endcase
    end else if (roll < 60) begin
      it.action = ACT_PICK;
    end else begin
      it.action = (roll < 85) ? ACT_REPORT : ACT_MARK;
      if (n > 0 && $urandom_range(4) != 0) it.port = sb.port_tbl[$urandom_range(n - 1)];
      it.request_total = random_total();
      it.error_total   = random_total();
    end
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  int unsigned active_plan [13] = '{16, 5, 31, 1, 17, 12, 0, 16, 8, 3, 16, 2, 20};

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slot count still zero after reset: nothing to pick, nothing to match,
    // but loads land anyway.
    send_item(make_request(ACT_PICK,   4'd0,  16'h0000, '0, '0));
    send_item(make_request(ACT_REPORT, 4'd0,  16'h0000, 32'd7, 32'd7));
    send_item(make_request(ACT_MARK,   4'd0,  16'h0000, '0, '0));
    send_item(make_request(ACT_LOAD,   4'd0,  16'hFFFF, '0, '0));
    send_item(make_request(ACT_LOAD,   4'd1,  16'h8001, '1, '1));
    send_item(make_request(ACT_LOAD,   4'd15, 16'h0000, '0, '0));

    // Oversized slot count: whole table scanned. Idle servers picked in slot
    // order, including one with port zero; duplicate port zero marks the
    // lowest slot; a miss on an unknown port.
    program_active_count(5'd31);
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_REPORT, 4'd0, 16'h8001, '1, '0));
    send_item(make_request(ACT_REPORT, 4'd0, 16'hFFFF, '1, '1));
    send_item(make_request(ACT_MARK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_MARK,   4'd0, 16'h5555, '0, '0));

    // Two slots, both counts saturated: error count breaks the tie and the
    // count stays at its maximum; then everything down, then back up.
    program_active_count(5'd2);
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_MARK,   4'd0, 16'h8001, '0, '0));
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_MARK,   4'd0, 16'hFFFF, '0, '0));
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));
    send_item(make_request(ACT_REPORT, 4'd0, 16'hFFFF, '0, '0));
    send_item(make_request(ACT_PICK,   4'd0, 16'h0000, '0, '0));

    // Random traffic: sender-light idling first, then receiver-light, then
    // none at all.
    for (int seg = 0; seg < 13; seg++) begin
      if (seg == 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 14;
      end else if (seg == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_active_count(ACTIVE_W'(active_plan[seg]));
      repeat (SEG_ITEMS) send_item(random_request());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
